// ----- rtl/packet_qos_field_classifier_assert.svh -----
// ----------------------------------------------------------------------------
// Packet QoS field classifier assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off while in reset.
// ----------------------------------------------------------------------------
`ifndef PACKET_QOS_FIELD_CLASSIFIER_ASSERT_SVH
`define PACKET_QOS_FIELD_CLASSIFIER_ASSERT_SVH

// same-cycle implication
`define PQFC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pqfc assertion failed");

// next-cycle implication
`define PQFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pqfc assertion failed");

`endif

// ----- rtl/pqfc_pkg.sv -----
// ----------------------------------------------------------------------------
// Packet QoS field classifier package
// Shared types, register codes, reset values and a helper function.
// ----------------------------------------------------------------------------
`default_nettype none

package pqfc_pkg;

  localparam int unsigned NUM_FIELDS = 3;
  localparam int unsigned POS_W      = 9;
  localparam int unsigned WIN_W      = 64;
  localparam int unsigned SHIFT_W    = 6;
  localparam int unsigned MAP_REGS   = 4;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  localparam int unsigned FLD_SUBPORT = 0;
  localparam int unsigned FLD_PIPE    = 1;
  localparam int unsigned FLD_CODE    = 2;

  localparam logic [23:0]      RST_OFFSETS   = 24'h082800;
  localparam logic [WIN_W-1:0] RST_SUB_MASK  = 64'h0;
  localparam logic [WIN_W-1:0] RST_PIPE_MASK = 64'h0000_000F_FF00_0000;
  localparam logic [WIN_W-1:0] RST_CODE_MASK = 64'h0000_0000_0000_00FC;
  localparam logic [WIN_W-1:0] RST_CLASS_MAP = 64'hFEDC_BA98_7654_3210;

  typedef enum logic [2:0] {
    REG_OFFSETS   = 3'd0,
    REG_SUB_MASK  = 3'd1,
    REG_PIPE_MASK = 3'd2,
    REG_CODE_MASK = 3'd3,
    REG_MAP_0     = 3'd4,
    REG_MAP_1     = 3'd5,
    REG_MAP_2     = 3'd6,
    REG_MAP_3     = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [23:0]                           offsets;
    logic [NUM_FIELDS-1:0][WIN_W-1:0]      mask;
    logic [NUM_FIELDS-1:0][SHIFT_W-1:0]    shift;
    logic [MAP_REGS-1:0][WIN_W-1:0]        class_map;
  } cfg_t;

  typedef struct packed {
    logic                              valid;
    logic [NUM_FIELDS-1:0][WIN_W-1:0]  word;
  } fields_t;

  // trailing-zero count, 63 for a zero word
  function automatic logic [SHIFT_W-1:0] trailing_zeros(input logic [WIN_W-1:0] v);
    logic [SHIFT_W-1:0] n;
    n = '1;
    for (int i = WIN_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        n = SHIFT_W'(i);
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/pqfc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Packet QoS field classifier configuration registers
// Offsets, masks with their shift counts, and the class map table.
// ----------------------------------------------------------------------------
`default_nettype none

module pqfc_cfg_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [2:0]       cfg_index_i,
  input  logic [63:0]      cfg_data_i,
  output pqfc_pkg::cfg_t   cfg_o
);
  import pqfc_pkg::*;

  cfg_t cfg_q, cfg_d;
  cfg_reg_e reg_sel;

  assign cfg_ready_o = 1'b1;
  assign reg_sel     = cfg_reg_e'(cfg_index_i);
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (reg_sel)
        REG_OFFSETS: begin
          cfg_d.offsets = cfg_data_i[23:0];
        end
        REG_SUB_MASK: begin
          cfg_d.mask[FLD_SUBPORT]  = cfg_data_i;
          cfg_d.shift[FLD_SUBPORT] = trailing_zeros(cfg_data_i);
        end
        REG_PIPE_MASK: begin
          cfg_d.mask[FLD_PIPE]  = cfg_data_i;
          cfg_d.shift[FLD_PIPE] = trailing_zeros(cfg_data_i);
        end
        REG_CODE_MASK: begin
          cfg_d.mask[FLD_CODE]  = cfg_data_i;
          cfg_d.shift[FLD_CODE] = trailing_zeros(cfg_data_i);
        end
        REG_MAP_0: cfg_d.class_map[0] = cfg_data_i;
        REG_MAP_1: cfg_d.class_map[1] = cfg_data_i;
        REG_MAP_2: cfg_d.class_map[2] = cfg_data_i;
        REG_MAP_3: cfg_d.class_map[3] = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.offsets            <= RST_OFFSETS;
      cfg_q.mask[FLD_SUBPORT]  <= RST_SUB_MASK;
      cfg_q.mask[FLD_PIPE]     <= RST_PIPE_MASK;
      cfg_q.mask[FLD_CODE]     <= RST_CODE_MASK;
      cfg_q.shift[FLD_SUBPORT] <= trailing_zeros(RST_SUB_MASK);
      cfg_q.shift[FLD_PIPE]    <= trailing_zeros(RST_PIPE_MASK);
      cfg_q.shift[FLD_CODE]    <= trailing_zeros(RST_CODE_MASK);
      for (int k = 0; k < MAP_REGS; k++) begin
        cfg_q.class_map[k] <= RST_CLASS_MAP;
      end
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pqfc_capture.sv -----
// ----------------------------------------------------------------------------
// Packet QoS field classifier capture stage
// Byte input register, position counter, window capture and field masking.
// ----------------------------------------------------------------------------
`default_nettype none

module pqfc_capture (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  input  pqfc_pkg::cfg_t    cfg_i,
  output pqfc_pkg::fields_t fields_o,
  input  logic              fields_ready_i
);
  import pqfc_pkg::*;

  logic                              s1_valid_q;
  logic [7:0]                        s1_byte_q;
  logic                              s1_last_q;
  logic [POS_W-1:0]                  s1_pos_q;
  logic [POS_W-1:0]                  pos_q, pos_d;
  logic [NUM_FIELDS-1:0][WIN_W-1:0]  win_q, win_upd;
  logic                              s2_valid_q;
  logic [NUM_FIELDS-1:0][WIN_W-1:0]  s2_word_q;
  logic                              s2_ready, s1_done, s1_ready, in_accept;

  assign s2_ready   = !s2_valid_q || fields_ready_i;
  assign s1_done    = s1_valid_q && (!s1_last_q || s2_ready);
  assign s1_ready   = !s1_valid_q || s1_done;
  assign in_stall_o = !s1_ready;
  assign in_accept  = in_valid_i && s1_ready;
  assign fields_o   = '{valid: s2_valid_q, word: s2_word_q};

  always_comb begin
    if (!in_accept) begin
      pos_d = pos_q;
    end else if (last_byte_i) begin
      pos_d = '0;
    end else if (pos_q == POS_MAX) begin
      pos_d = pos_q;
    end else begin
      pos_d = pos_q + POS_W'(1);
    end
  end

  always_comb begin
    logic [POS_W-1:0] off;
    logic [POS_W-1:0] rel;
    for (int f = 0; f < NUM_FIELDS; f++) begin
      off = {1'b0, cfg_i.offsets[8*f +: 8]};
      rel = s1_pos_q - off;
      win_upd[f] = win_q[f];
      if (s1_pos_q >= off && rel[POS_W-1:3] == '0) begin
        win_upd[f] = win_q[f] | ({56'd0, s1_byte_q} << {~rel[2:0], 3'b000});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      s1_valid_q <= 1'b0;
      win_q      <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_done) begin
        win_q <= s1_last_q ? '0 : win_upd;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q && s1_last_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_byte_i;
      s1_pos_q  <= pos_q;
    end
    if (s2_ready && s1_valid_q && s1_last_q) begin
      for (int f = 0; f < NUM_FIELDS; f++) begin
        s2_word_q[f] <= win_upd[f] & cfg_i.mask[f];
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pqfc_extract.sv -----
// ----------------------------------------------------------------------------
// Packet QoS field classifier extract stage
// Aligns masked fields, looks up the class map and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module pqfc_extract (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pqfc_pkg::fields_t fields_i,
  output logic              fields_ready_o,
  input  pqfc_pkg::cfg_t    cfg_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [15:0]       subport_o,
  output logic [31:0]       pipe_o,
  output logic [1:0]        sched_class_o,
  output logic [1:0]        class_queue_o
);
  import pqfc_pkg::*;

  logic              out_valid_q;
  logic [15:0]       sub_q;
  logic [31:0]       pipe_q;
  logic [1:0]        tc_q, queue_q;
  logic              out_ready;
  logic [WIN_W-1:0]  sub_al, pipe_al, code_al, map_row;
  logic [5:0]        idx;
  logic [3:0]        entry;

  assign out_ready      = !out_valid_q || !out_stall_i;
  assign fields_ready_o = out_ready;

  assign sub_al  = fields_i.word[FLD_SUBPORT] >> cfg_i.shift[FLD_SUBPORT];
  assign pipe_al = fields_i.word[FLD_PIPE] >> cfg_i.shift[FLD_PIPE];
  assign code_al = fields_i.word[FLD_CODE] >> cfg_i.shift[FLD_CODE];
  assign idx     = code_al[5:0];
  assign map_row = cfg_i.class_map[idx[5:4]] >> {idx[3:0], 2'b00};
  assign entry   = map_row[3:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= fields_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && fields_i.valid) begin
      sub_q   <= sub_al[15:0];
      pipe_q  <= pipe_al[31:0];
      tc_q    <= entry[3:2];
      queue_q <= entry[1:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign subport_o     = sub_q;
  assign pipe_o        = pipe_q;
  assign sched_class_o = tc_q;
  assign class_queue_o = queue_q;

endmodule

`default_nettype wire

// ----- rtl/packet_qos_field_classifier.sv -----
// ----------------------------------------------------------------------------
// Packet QoS field classifier
// Captures subport, pipe and class code windows from a byte stream and
// maps the class code to a traffic class and queue at each packet end.
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  in       input      in_valid_i/in_stall_o   data_byte_i, last_byte_i
//  out      output     out_valid_o/out_stall_i subport_o, pipe_o,
//                                              sched_class_o, class_queue_o
//  cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
//  One byte is taken per cycle, back to back, while in_stall_o is low; the
//  byte, field and output registers each take a new transaction every cycle
//  unless held by a stall. Once its last byte is accepted, a result moves
//  from the byte register through the field and output registers. Reset loads
//  the default registers and clears the byte position and windows. in_stall_o
//  rises only while the output is held, the field register is full and a packet end waits in the byte register.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_qos_field_classifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] subport_o,
  output logic [31:0] pipe_o,
  output logic [1:0]  sched_class_o,
  output logic [1:0]  class_queue_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import pqfc_pkg::*;

  cfg_t    cfg;
  fields_t fields;
  logic    fields_ready;

  pqfc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  pqfc_capture u_capture (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .cfg_i          (cfg),
    .fields_o       (fields),
    .fields_ready_i (fields_ready)
  );

  pqfc_extract u_extract (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fields_i       (fields),
    .fields_ready_o (fields_ready),
    .cfg_i          (cfg),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .subport_o      (subport_o),
    .pipe_o         (pipe_o),
    .sched_class_o  (sched_class_o),
    .class_queue_o  (class_queue_o)
  );

`include "packet_qos_field_classifier_assert.svh"

  `PQFC_ASSERT_IMPL(a_stall_only_when_blocked, in_stall_o, out_valid_o && out_stall_i)
  `PQFC_ASSERT_NEXT(a_fields_reach_output, fields.valid && !(out_valid_o && out_stall_i),
                    out_valid_o)
  `PQFC_ASSERT_NEXT(a_output_drains, out_valid_o && !out_stall_i && !fields.valid,
                    !out_valid_o)

endmodule

`default_nettype wire
